/* rtl/core/urlpd_pkg.sv */
// Package for the URL percent decoder: beat payload types, decoder state,
// status codes, character constants and the hex digit helper. No dependencies.
package urlpd_pkg;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       has_byte;
      logic       string_done;
      logic [2:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_LOW  = 2'd2
   } phase_type;

   typedef logic [2:0] status_type;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_TRUNCATED = 3'd1;
   localparam status_type ST_BAD_HEX   = 3'd2;
   localparam status_type ST_ZERO      = 3'd3;
   localparam status_type ST_CONTROL   = 3'd4;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] high_nibble;
      logic       high_invalid;
      status_type error_code;
   } state_type;

   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'h7f;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] d;
      d = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = {1'b0, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         d = {1'b0, b[3:0] + 4'd9};
      end
      return d;
   endfunction

endpackage

/* rtl/core/urlpd_decode.sv */
// One decode step: current state and one input beat give the next state and
// the result beat. Pure combinational logic. Depends on urlpd_pkg.
module urlpd_decode (
   input  urlpd_pkg::state_type cur_state,
   input  urlpd_pkg::req_type   item,
   output urlpd_pkg::state_type next_state,
   output urlpd_pkg::rsp_type   result,
   output logic                 has_result
);

   logic [4:0]           digit;
   urlpd_pkg::state_type upd;
   logic                 emit;
   logic [7:0]           val;
   logic                 ctrl_byte;

   assign digit     = urlpd_pkg::hex_digit(item.code_byte);
   assign ctrl_byte = (item.code_byte < urlpd_pkg::CTRL_LIMIT) ||
                      (item.code_byte == urlpd_pkg::CH_DEL);

   // next state
   always_comb begin
      upd = cur_state;
      if (cur_state.error_code == urlpd_pkg::ST_OK) begin
         unique case (cur_state.phase)
            urlpd_pkg::PHASE_HIGH: begin
               upd.high_invalid = digit[4];
               upd.high_nibble  = digit[3:0];
               upd.phase        = urlpd_pkg::PHASE_LOW;
            end
            urlpd_pkg::PHASE_LOW: begin
               upd.phase        = urlpd_pkg::PHASE_IDLE;
               upd.high_nibble  = 4'd0;
               upd.high_invalid = 1'b0;
               if (cur_state.high_invalid || digit[4]) begin
                  upd.error_code = urlpd_pkg::ST_BAD_HEX;
               end else if ({cur_state.high_nibble, digit[3:0]} == 8'd0) begin
                  upd.error_code = urlpd_pkg::ST_ZERO;
               end
            end
            default: begin
               upd.phase = urlpd_pkg::PHASE_IDLE;
               priority if (item.code_byte == urlpd_pkg::CH_PLUS) begin
                  upd.phase = urlpd_pkg::PHASE_IDLE;
               end else if (item.code_byte == urlpd_pkg::CH_PERCENT) begin
                  upd.phase = urlpd_pkg::PHASE_HIGH;
               end else if (ctrl_byte) begin
                  upd.error_code = urlpd_pkg::ST_CONTROL;
               end else begin
                  upd.phase = urlpd_pkg::PHASE_IDLE;
               end
            end
         endcase
         if (item.end_of_string && upd.error_code == urlpd_pkg::ST_OK &&
             upd.phase != urlpd_pkg::PHASE_IDLE) begin
            upd.error_code = urlpd_pkg::ST_TRUNCATED;
         end
      end
      next_state = item.end_of_string ? '0 : upd;
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      val  = 8'd0;
      if (cur_state.error_code == urlpd_pkg::ST_OK) begin
         unique case (cur_state.phase)
            urlpd_pkg::PHASE_HIGH: begin
               emit = 1'b0;
            end
            urlpd_pkg::PHASE_LOW: begin
               val  = {cur_state.high_nibble, digit[3:0]};
               emit = !cur_state.high_invalid && !digit[4] && (val != 8'd0);
            end
            default: begin
               priority if (item.code_byte == urlpd_pkg::CH_PLUS) begin
                  val  = urlpd_pkg::CH_SPACE;
                  emit = 1'b1;
               end else if (item.code_byte == urlpd_pkg::CH_PERCENT || ctrl_byte) begin
                  emit = 1'b0;
               end else begin
                  val  = item.code_byte;
                  emit = 1'b1;
               end
            end
         endcase
      end
      result.plain_byte  = emit ? val : 8'd0;
      result.has_byte    = emit;
      result.string_done = item.end_of_string;
      result.status      = item.end_of_string ? upd.error_code : urlpd_pkg::ST_OK;
      has_result         = emit || item.end_of_string;
   end

endmodule

/* rtl/core/url_percent_decoder.sv */
// Top level of the URL percent decoder: input register, decode state and
// result register around urlpd_decode. Depends on urlpd_pkg, urlpd_decode.
//
//   port group  dir  payload              handshake
//   req_        in   urlpd_pkg::req_type  req_valid / req_stall
//   rsp_        out  urlpd_pkg::rsp_type  rsp_valid / rsp_stall
//
// One byte per clock sustained while rsp_stall is low. A byte passes the
// input register, then is decoded into the result register. The decode
// state updates as a beat leaves the input register. Synchronous reset
// clears valids and state. A stalled result holds the input register;
// req_stall rises only when that register is full and cannot drain.
module url_percent_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  urlpd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output urlpd_pkg::rsp_type rsp_data
);

   logic                 in_valid_ff, in_valid_in;
   urlpd_pkg::req_type   in_data_ff, in_data_in;
   logic                 out_valid_ff, out_valid_in;
   urlpd_pkg::rsp_type   out_data_ff, out_data_in;
   urlpd_pkg::state_type state_ff, state_in;

   urlpd_pkg::state_type dec_state;
   urlpd_pkg::rsp_type   dec_result;
   logic                 dec_has_result;
   logic                 out_free;
   logic                 move;

   urlpd_decode u_decode (
      .cur_state  (state_ff),
      .item       (in_data_ff),
      .next_state (dec_state),
      .result     (dec_result),
      .has_result (dec_has_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !move;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      state_in     = state_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
      if (out_free) begin
         out_valid_in = move && dec_has_result;
      end
      if (move) begin
         out_data_in = dec_result;
         state_in    = dec_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* bench/url_percent_decoder_tb.sv */
// Self-checking bench for url_percent_decoder: a directed table of encoded
// strings, then random strings; each result checked against its typed row or
// a decode model. Depends on urlpd_pkg and url_percent_decoder.
module url_percent_decoder_tb;
   import urlpd_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_BEATS  = 1150;
   localparam int IDLE_PERCENT  = 38;
   localparam int CALM_FROM     = 700;
   localparam int CALM_TO       = 950;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 10;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 200;

   typedef struct packed {
      req_type beat;
      logic    typed;
      logic    typed_out;
      rsp_type typed_rsp;
   } row_type;

   typedef enum logic [1:0] {
      FLAW_CONTROL,
      FLAW_BAD_HIGH,
      FLAW_BAD_LOW,
      FLAW_ZERO
   } flaw_type;

   localparam rsp_type NO_RSP = '0;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   row_type offer_row = '0;
   logic    calm;

   phase_type  dec_phase    = PHASE_IDLE;
   logic [3:0] dec_high     = 4'h0;
   logic       dec_high_bad = 1'b0;
   status_type dec_error    = ST_OK;

   rsp_type expected_q[$];
   row_type stim_q[$];

   int beats_taken    = 0;
   int results_seen   = 0;
   int strings_done   = 0;
   int strings_failed = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   // typed rows carry their result; the others go through decode_beat
   row_type script [DIRECTED_ROWS] = '{
      '{'{8'h41, 1'b1}, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, ST_OK}},
      '{'{8'h20, 1'b0}, 1'b1, 1'b1, '{8'h20, 1'b1, 1'b0, ST_OK}},
      '{'{8'h7e, 1'b0}, 1'b1, 1'b1, '{8'h7e, 1'b1, 1'b0, ST_OK}},
      '{'{8'h80, 1'b0}, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b0, ST_OK}},
      '{'{8'hff, 1'b1}, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, ST_OK}},
      '{'{CH_PLUS, 1'b1}, 1'b1, 1'b1, '{CH_SPACE, 1'b1, 1'b1, ST_OK}},
      '{'{CH_PERCENT, 1'b0}, 1'b1, 1'b0, NO_RSP},
      '{'{8'h34, 1'b0}, 1'b1, 1'b0, NO_RSP},
      '{'{8'h31, 1'b1}, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, ST_OK}},
      '{'{CH_PERCENT, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h66, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h46, 1'b1}, 1'b0, 1'b0, NO_RSP},
      '{'{CH_PERCENT, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNCATED}},
      '{'{CH_PERCENT, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h61, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNCATED}},
      '{'{CH_PERCENT, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h67, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h31, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_HEX}},
      '{'{CH_PERCENT, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h30, 1'b0}, 1'b0, 1'b0, NO_RSP},
      '{'{8'h30, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_ZERO}},
      '{'{8'h00, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_CONTROL}},
      '{'{CH_DEL, 1'b0}, 1'b1, 1'b0, NO_RSP},
      '{'{8'h78, 1'b0}, 1'b1, 1'b0, NO_RSP},
      '{'{8'h1f, 1'b1}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_CONTROL}}
   };

   assign req_data = offer_row.beat;
   assign calm = beats_taken >= CALM_FROM && beats_taken < CALM_TO;

   always #(HALF_PERIOD) clock = ~clock;

   url_percent_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // bit 4 set: not a hex digit
   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      logic [7:0] folded;
      folded = ch | 8'h20;
      if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, 4'(ch - 8'h30)};
      if (folded >= 8'h61 && folded <= 8'h66) return {1'b0, 4'(folded - 8'h57)};
      return 5'h10;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] not_hex_char();
      logic [7:0] ch;
      logic [4:0] digit;
      do begin
         ch = 8'($urandom_range(0, 255));
         digit = nibble_of(ch);
      end while (!digit[4]);
      return ch;
   endfunction

   function automatic logic decode_beat(input req_type beat, output rsp_type res);
      logic [4:0] digit;
      logic [7:0] value;
      logic       emit;
      value = 8'h00;
      emit = 1'b0;
      res = NO_RSP;
      if (dec_error == ST_OK) begin
         case (dec_phase)
            PHASE_HIGH: begin
               digit = nibble_of(beat.code_byte);
               dec_high_bad = digit[4];
               dec_high = digit[3:0];
               dec_phase = PHASE_LOW;
            end
            PHASE_LOW: begin
               digit = nibble_of(beat.code_byte);
               dec_phase = PHASE_IDLE;
               if (dec_high_bad || digit[4]) begin
                  dec_error = ST_BAD_HEX;
               end else begin
                  value = {dec_high, digit[3:0]};
                  if (value == 8'h00) begin
                     dec_error = ST_ZERO;
                  end else begin
                     emit = 1'b1;
                  end
               end
               dec_high = 4'h0;
               dec_high_bad = 1'b0;
            end
            default: begin
               dec_phase = PHASE_IDLE;
               if (beat.code_byte == CH_PLUS) begin
                  value = CH_SPACE;
                  emit = 1'b1;
               end else if (beat.code_byte == CH_PERCENT) begin
                  dec_phase = PHASE_HIGH;
               end else if (beat.code_byte < CTRL_LIMIT || beat.code_byte == CH_DEL) begin
                  dec_error = ST_CONTROL;
               end else begin
                  value = beat.code_byte;
                  emit = 1'b1;
               end
            end
         endcase
         if (beat.end_of_string && dec_error == ST_OK && dec_phase != PHASE_IDLE) begin
            dec_error = ST_TRUNCATED;
         end
      end
      if (!emit && !beat.end_of_string) return 1'b0;
      res.plain_byte  = emit ? value : 8'h00;
      res.has_byte    = emit;
      res.string_done = beat.end_of_string;
      res.status      = beat.end_of_string ? dec_error : ST_OK;
      if (beat.end_of_string) begin
         dec_phase = PHASE_IDLE;
         dec_high = 4'h0;
         dec_high_bad = 1'b0;
         dec_error = ST_OK;
      end
      return 1'b1;
   endfunction

   // mostly clean strings; some with one flaw, some cut off inside an escape,
   // a few of raw noise
   task automatic add_string();
      logic [7:0] text[$];
      logic [7:0] ch;
      row_type    row;
      int         kind, tokens, flaw_at, pick, t;
      kind = $urandom_range(0, 99);
      tokens = $urandom_range(1, 10);
      flaw_at = (kind >= 5 && kind < 22) ? $urandom_range(0, tokens - 1) : -1;
      for (t = 0; t < tokens; t++) begin
         if (kind < 5) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (t == flaw_at) begin
            case (flaw_type'($urandom_range(0, 3)))
               FLAW_CONTROL: begin
                  text.push_back($urandom_range(0, 1) ? CH_DEL : 8'($urandom_range(0, 31)));
               end
               FLAW_BAD_HIGH: begin
                  text.push_back(CH_PERCENT);
                  text.push_back(not_hex_char());
                  text.push_back(hex_char(4'($urandom)));
               end
               FLAW_BAD_LOW: begin
                  text.push_back(CH_PERCENT);
                  text.push_back(hex_char(4'($urandom)));
                  text.push_back(not_hex_char());
               end
               default: begin
                  text.push_back(CH_PERCENT);
                  text.push_back(hex_char(4'h0));
                  text.push_back(hex_char(4'h0));
               end
            endcase
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               ch = 8'($urandom_range(8'h20, 8'h7e));
               text.push_back(ch == CH_PERCENT ? CH_PLUS : ch);
            end else if (pick < 55) begin
               text.push_back(CH_PLUS);
            end else if (pick < 85) begin
               ch = 8'($urandom_range(1, 255));
               text.push_back(CH_PERCENT);
               text.push_back(hex_char(ch[7:4]));
               text.push_back(hex_char(ch[3:0]));
            end else begin
               text.push_back(8'($urandom_range(8'h80, 8'hff)));
            end
         end
      end
      if (kind >= 22 && kind < 30) begin
         text.push_back(CH_PERCENT);
         if ($urandom_range(0, 1)) begin
            text.push_back($urandom_range(0, 1) ? hex_char(4'($urandom)) : not_hex_char());
         end
      end
      foreach (text[i]) begin
         row = '0;
         row.beat.code_byte = text[i];
         row.beat.end_of_string = (i == text.size() - 1);
         stim_q.push_back(row);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type want;
      logic    produced;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            beats_taken++;
            produced = decode_beat(offer_row.beat, predicted);
            if (offer_row.typed) begin
               if (offer_row.typed_out) expected_q.push_back(offer_row.typed_rsp);
            end else if (produced) begin
               expected_q.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat, plain_byte", rsp_data.plain_byte, 8'h00);
            end else begin
               want = expected_q.pop_front();
               if (want.string_done) begin
                  strings_done++;
                  if (want.status != ST_OK) strings_failed++;
               end
               if (rsp_data.plain_byte !== want.plain_byte) begin
                  report_mismatch("plain_byte", rsp_data.plain_byte, want.plain_byte);
               end
               if (rsp_data.has_byte !== want.has_byte) begin
                  report_mismatch("has_byte", 8'(rsp_data.has_byte), 8'(want.has_byte));
               end
               if (rsp_data.string_done !== want.string_done) begin
                  report_mismatch("string_done", 8'(rsp_data.string_done),
                                  8'(want.string_done));
               end
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 8'(rsp_data.status), 8'(want.status));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", quiet_cycles);
            $display("FAIL url_percent_decoder");
            $finish;
         end
      end
   end

   // long hold-off once, so the block backs up and stalls its input
   initial begin : receiver
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && beats_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      row_type row;
      foreach (script[i]) stim_q.push_back(script[i]);
      while (stim_q.size() < DIRECTED_ROWS + RANDOM_BEATS) add_string();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0) begin
         row = stim_q.pop_front();
         while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         offer_row <= row;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d encoded beats in, %0d results checked over %0d strings",
               beats_taken, results_seen, strings_done);
      $display("%0d strings ended with an error status, %0d mismatches",
               strings_failed, mismatches);
      if (mismatches == 0) begin
         $display("PASS url_percent_decoder");
      end else begin
         $display("FAIL url_percent_decoder");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/urlpd_pkg.sv
rtl/core/urlpd_decode.sv
rtl/core/url_percent_decoder.sv
bench/url_percent_decoder_tb.sv
